FILE: rtl/htpr_pkg.sv
// ----------------------------------------------------------------------------
// htpr_pkg
// Shared types, constants and helpers for the probe/replace hash table.
// ----------------------------------------------------------------------------
package htpr_pkg;

	localparam int INDEX_BITS_DEF = 16;
	localparam int QUEUE_DEPTH    = 2;

	localparam logic [6:0]  DEPTH_MAX     = 7'd127;
	localparam logic [1:0]  BOUND_EXACT   = 2'd3;
	localparam logic        ACT_PROBE     = 1'b0;
	localparam logic        ACT_STORE     = 1'b1;
	localparam logic [15:0] MOVE_NONE     = 16'd0;

	localparam logic [6:0]  AGE_RESET     = 7'd0;
	localparam logic [14:0] THR_RESET     = 15'd32000;
	localparam logic        REG_SEL_AGE   = 1'b0;
	localparam logic        REG_SEL_THR   = 1'b1;

	typedef struct packed {
		logic               action;
		logic [63:0]        key;
		logic [7:0]         ply;
		logic signed [7:0]  depth;
		logic [1:0]         bound;
		logic [15:0]        move;
		logic signed [15:0] eval;
		logic signed [15:0] value;
	} in_item_t;

	typedef struct packed {
		logic               hit;
		logic [6:0]         entry_age;
		logic [6:0]         entry_depth;
		logic [1:0]         entry_bound;
		logic [15:0]        entry_move;
		logic signed [15:0] entry_eval;
		logic signed [15:0] entry_value;
	} out_item_t;

	// classified item as it waits for the back end
	typedef struct packed {
		logic               action;
		logic [63:0]        key;
		logic [7:0]         ply;
		logic signed [7:0]  depth;
		logic [6:0]         depth_clamp;
		logic               exact;
		logic [1:0]         bound;
		logic [15:0]        move;
		logic [15:0]        eval;
		logic [15:0]        value_adj;
	} q_item_t;

	// mate-score ply adjustment, wraps to 16 bits
	function automatic logic [15:0] ply_adjust(
		input logic [15:0] v,
		input logic [7:0]  ply,
		input logic [14:0] thr,
		input logic        storing
	);
		logic signed [17:0] vx;
		logic signed [17:0] tx;
		logic signed [17:0] px;
		logic signed [17:0] r;
		vx = $signed({{2{v[15]}}, v});
		tx = $signed({3'b000, thr});
		px = $signed({10'd0, ply});
		r  = vx;
		if (vx >= tx) begin
			r = storing ? (vx + px) : (vx - px);
		end else if (vx <= -tx) begin
			r = storing ? (vx - px) : (vx + px);
		end
		return r[15:0];
	endfunction

endpackage

FILE: rtl/htpr_front.sv
// ----------------------------------------------------------------------------
// htpr_front
// Accepts items, clamps depth and applies the store-side value adjustment.
// ----------------------------------------------------------------------------
module htpr_front import htpr_pkg::*; (
	input  logic      in_valid,
	output logic      in_stall,
	input  in_item_t  in_item,
	input  logic      queue_full,
	input  logic      clearing,
	input  logic [14:0] mate_threshold,
	output logic      push,
	output q_item_t   push_item
);

	assign in_stall = queue_full | clearing;
	assign push     = in_valid & ~in_stall;

	always_comb begin
		push_item.action      = in_item.action;
		push_item.key         = in_item.key;
		push_item.ply         = in_item.ply;
		push_item.depth       = in_item.depth;
		push_item.depth_clamp = in_item.depth[7] ? 7'd0 : in_item.depth[6:0];
		push_item.exact       = (in_item.bound == BOUND_EXACT);
		push_item.bound       = in_item.bound;
		push_item.move        = in_item.move;
		push_item.eval        = in_item.eval;
		push_item.value_adj   = ply_adjust(in_item.value, in_item.ply, mate_threshold, 1'b1);
	end

endmodule

FILE: rtl/htpr_queue.sv
// ----------------------------------------------------------------------------
// htpr_queue
// Short FIFO between the front and back ends.
// ----------------------------------------------------------------------------
module htpr_queue import htpr_pkg::*; #(
	parameter int DEPTH = QUEUE_DEPTH
) (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    push,
	input  q_item_t push_item,
	input  logic    pop,
	output logic    empty,
	output logic    full,
	output q_item_t head
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	q_item_t            slot_q [DEPTH];
	logic [PTR_W-1:0]   wr_ptr_q;
	logic [PTR_W-1:0]   rd_ptr_q;
	logic [CNT_W-1:0]   cnt_q;

	assign empty = (cnt_q == '0);
	assign full  = (cnt_q == CNT_W'(DEPTH));
	assign head  = slot_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= push_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

endmodule

FILE: rtl/htpr_back.sv
// ----------------------------------------------------------------------------
// htpr_back
// Table memory, read-modify-write sequencer, clearing pass and result register.
// ----------------------------------------------------------------------------
module htpr_back import htpr_pkg::*; #(
	parameter int INDEX_BITS = INDEX_BITS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic [6:0]  current_age,
	input  logic [14:0] mate_threshold,
	input  logic        queue_empty,
	input  q_item_t     head,
	output logic        pop,
	output logic        clearing,
	output logic        out_valid,
	input  logic        out_stall,
	output out_item_t   out_item
);

	localparam int SLOTS = 1 << INDEX_BITS;

	localparam logic [1:0] ST_CLEAR = 2'd0;
	localparam logic [1:0] ST_IDLE  = 2'd1;
	localparam logic [1:0] ST_EVAL  = 2'd2;

	logic [63:0] chk_mem [SLOTS];
	logic [63:0] dat_mem [SLOTS];

	logic [1:0]            st_q;
	logic [INDEX_BITS-1:0] clr_q;
	q_item_t               cur_q;
	logic [63:0]           chk_rd_q;
	logic [63:0]           dat_rd_q;
	logic                  out_valid_q;
	out_item_t             out_item_q;

	logic                  wr_en;
	logic [INDEX_BITS-1:0] wr_addr;
	logic [63:0]           wr_chk;
	logic [63:0]           wr_dat;
	logic                  load_out;
	logic                  out_free;

	logic [63:0] old_key;
	logic [6:0]  old_age;
	logic [6:0]  old_depth;
	logic [15:0] old_move;
	logic        hit;
	logic        replace;
	logic [15:0] new_move;
	logic [63:0] new_dat;
	out_item_t   res;

	assign clearing = (st_q == ST_CLEAR);
	assign pop      = (st_q == ST_IDLE) && !queue_empty;
	assign out_free = !out_valid_q || !out_stall;

	always_comb begin
		old_key   = chk_rd_q ^ dat_rd_q;
		old_age   = dat_rd_q[6:0];
		old_depth = dat_rd_q[13:7];
		old_move  = dat_rd_q[31:16];
		hit       = ((chk_rd_q ^ cur_q.key) == dat_rd_q);
		replace   = (old_age != current_age) || (old_key != cur_q.key) || cur_q.exact ||
			($signed({2'b00, old_depth}) < $signed({cur_q.depth[7], cur_q.depth}));
		new_move  = ((old_key == cur_q.key) && (cur_q.move == MOVE_NONE)) ? old_move : cur_q.move;
		new_dat   = {cur_q.value_adj, cur_q.eval, new_move, cur_q.bound,
			cur_q.depth_clamp, current_age};

		res = '0;
		if (hit) begin
			res.hit         = 1'b1;
			res.entry_age   = old_age;
			res.entry_depth = old_depth;
			res.entry_bound = dat_rd_q[15:14];
			res.entry_move  = old_move;
			res.entry_eval  = dat_rd_q[47:32];
			res.entry_value = ply_adjust(dat_rd_q[63:48], cur_q.ply, mate_threshold, 1'b0);
		end

		wr_en   = 1'b0;
		wr_addr = clr_q;
		wr_chk  = '0;
		wr_dat  = '0;
		load_out = 1'b0;
		case (st_q)
			ST_CLEAR: begin
				wr_en = 1'b1;
			end
			ST_EVAL: begin
				if (cur_q.action == ACT_STORE) begin
					wr_en   = replace;
					wr_addr = cur_q.key[INDEX_BITS-1:0];
					wr_chk  = cur_q.key ^ new_dat;
					wr_dat  = new_dat;
				end else begin
					load_out = out_free;
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			chk_mem[wr_addr] <= wr_chk;
			dat_mem[wr_addr] <= wr_dat;
		end
		if (pop) begin
			chk_rd_q <= chk_mem[head.key[INDEX_BITS-1:0]];
			dat_rd_q <= dat_mem[head.key[INDEX_BITS-1:0]];
			cur_q    <= head;
		end
		if (load_out) begin
			out_item_q <= res;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q        <= ST_CLEAR;
			clr_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			case (st_q)
				ST_CLEAR: begin
					clr_q <= clr_q + 1'b1;
					if (clr_q == '1) begin
						st_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (pop) begin
						st_q <= ST_EVAL;
					end
				end
				ST_EVAL: begin
					if (cur_q.action == ACT_STORE || out_free) begin
						st_q <= ST_IDLE;
					end
				end
				default: begin
					st_q <= ST_IDLE;
				end
			endcase
			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid = out_valid_q;
	assign out_item  = out_item_q;

	a_no_pop_while_clearing: assert property (@(posedge clk) disable iff (!arst_n)
		(st_q == ST_CLEAR) |-> !pop)
		else $error("queue popped during clearing pass");

	a_pop_leads_to_eval: assert property (@(posedge clk) disable iff (!arst_n)
		pop |=> (st_q == ST_EVAL))
		else $error("read issued without evaluation cycle");

	a_write_source: assert property (@(posedge clk) disable iff (!arst_n)
		wr_en |-> (st_q == ST_CLEAR) || ((st_q == ST_EVAL) && (cur_q.action == ACT_STORE)))
		else $error("table written outside clear or store");

	a_result_only_from_probe: assert property (@(posedge clk) disable iff (!arst_n)
		load_out |-> (cur_q.action == ACT_PROBE) && out_free)
		else $error("result loaded by store or over a pending result");

endmodule

FILE: rtl/hash_table_probe_replace.sv
// ----------------------------------------------------------------------------
// hash_table_probe_replace
// Direct-mapped search hash table with lockless-style check words and an
// age/depth/exact-bound replacement rule.
// ----------------------------------------------------------------------------
//
//  channel  | handshake                       | payload
//  ---------+---------------------------------+------------------------------
//  in       | in_valid / in_stall             | in_item  (in_item_t)
//  out      | out_valid / out_stall           | out_item (out_item_t)
//  config   | APB psel/penable/pwrite/pready  | paddr[2] selects, pwdata
//
//  In the back end an item is first popped from the queue and its slot read
//  (idle state), then compared and the slot written (store) or the result
//  register loaded (probe) in the eval state.
//  After reset a clearing pass zeroes every slot of the table, during which
//  in_stall is high; config writes are still taken.
//  A stalled result holds the back end only for probes; stores keep moving,
//  and the two-entry queue lets the input side run ahead of the back end.
//
module hash_table_probe_replace import htpr_pkg::*; #(
	parameter int INDEX_BITS = INDEX_BITS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,

	input  logic        in_valid,
	output logic        in_stall,
	input  in_item_t    in_item,

	output logic        out_valid,
	input  logic        out_stall,
	output out_item_t   out_item,

	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	// configuration registers
	logic [6:0]  age_q;
	logic [14:0] thr_q;
	logic        cfg_wr;

	// front to queue to back
	logic    push;
	q_item_t push_item;
	logic    pop;
	logic    q_empty;
	logic    q_full;
	q_item_t q_head;
	logic    clearing;

	assign pready = 1'b1;
	assign cfg_wr = psel & penable & pwrite;

	// byte offset bits are ignored; bit 2 picks the register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			age_q <= AGE_RESET;
			thr_q <= THR_RESET;
		end else if (cfg_wr) begin
			case (paddr[2])
				REG_SEL_AGE: age_q <= pwdata[6:0];
				REG_SEL_THR: thr_q <= pwdata[14:0];
				default: begin
				end
			endcase
		end
	end

	always_comb begin
		case (paddr[2])
			REG_SEL_AGE: prdata = {25'd0, age_q};
			REG_SEL_THR: prdata = {17'd0, thr_q};
			default:     prdata = '0;
		endcase
	end

	// front: accept and classify transfers
	htpr_front u_front (
		.in_valid       (in_valid),
		.in_stall       (in_stall),
		.in_item        (in_item),
		.queue_full     (q_full),
		.clearing       (clearing),
		.mate_threshold (thr_q),
		.push           (push),
		.push_item      (push_item)
	);

	// decoupling queue
	htpr_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_item (push_item),
		.pop       (pop),
		.empty     (q_empty),
		.full      (q_full),
		.head      (q_head)
	);

	// back: table access and result transfer
	htpr_back #(
		.INDEX_BITS (INDEX_BITS)
	) u_back (
		.clk            (clk),
		.arst_n         (arst_n),
		.current_age    (age_q),
		.mate_threshold (thr_q),
		.queue_empty    (q_empty),
		.head           (q_head),
		.pop            (pop),
		.clearing       (clearing),
		.out_valid      (out_valid),
		.out_stall      (out_stall),
		.out_item       (out_item)
	);

endmodule

FILE: verif/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for hash_table_probe_replace: directed probes and stores
// on hand-picked keys, then random traffic over a small key pool with collisions
// under four idle/stall patterns and several register settings. Each probe
// result is checked field by field against a bench-side model of the table.
// ----------------------------------------------------------------------------
module testbench;
	timeunit 1ns;
	timeprecision 1ps;
	import htpr_pkg::*;

	localparam int          CLEAR_CYCLES  = 1 << INDEX_BITS_DEF;
	localparam int          CYCLE_LIMIT   = CLEAR_CYCLES + 600000;
	localparam int          SETTLE_CYCLES = 8;	// back end is two deep plus queue
	localparam int          POOL_SIZE     = 24;
	localparam int          PHASE_ITEMS   = 332;
	localparam logic [2:0]  ADDR_AGE      = {REG_SEL_AGE, 2'b00};
	localparam logic [2:0]  ADDR_THR      = {REG_SEL_THR, 2'b00};

	logic        clk      = 1'b0;
	logic        arst_n   = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_stall;
	in_item_t    in_item  = '0;
	logic        out_valid;
	logic        out_stall = 1'b0;
	out_item_t   out_item;
	logic        psel    = 1'b0;
	logic        penable = 1'b0;
	logic        pwrite  = 1'b0;
	logic [2:0]  paddr   = '0;
	logic [31:0] pwdata  = '0;
	logic [31:0] prdata;
	logic        pready;

	// bench copy of the registers and the table (absent slot = cleared)
	logic [6:0]  model_age = AGE_RESET;
	logic [14:0] model_thr = THR_RESET;
	logic [63:0] check_tab [int unsigned];
	logic [63:0] data_tab  [int unsigned];

	in_item_t    pending_items [$];	// transfers waiting for the driver
	out_item_t   probe_results [$];	// probe results still owed by the block
	logic [63:0] key_pool [POOL_SIZE];

	int unsigned send_idle_pct  = 0;
	int unsigned recv_stall_pct = 0;
	int          calm_left      = 0;
	int          errors         = 0;
	int          cycles         = 0;
	bit          in_taken       = 1'b0;

	always #6 clk = ~clk;

	hash_table_probe_replace #(.INDEX_BITS(INDEX_BITS_DEF)) dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.in_item  (in_item),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.out_item (out_item),
		.psel     (psel),
		.penable  (penable),
		.pwrite   (pwrite),
		.paddr    (paddr),
		.pwdata   (pwdata),
		.prdata   (prdata),
		.pready   (pready)
	);

	// Mate-score ply shift. Storing pushes mate scores away from zero by ply,
	// loading pulls them back; the result wraps to 16 bits.
	function automatic logic [15:0] mate_shift(input logic [15:0] v, input logic [7:0] ply,
			input bit storing);
		int vi;
		int t;
		int p;
		int r;
		vi = $signed(v);
		t  = model_thr;
		p  = ply;
		r  = vi;
		if (vi >= t) begin
			r = storing ? vi + p : vi - p;
		end else if (vi <= -t) begin
			r = storing ? vi - p : vi + p;
		end
		return r[15:0];
	endfunction

	// Apply one accepted transfer to the bench table; probes queue a result.
	function automatic void apply_table_op(input in_item_t it);
		int unsigned slot;
		logic [63:0] chk;
		logic [63:0] dat;
		logic [63:0] old_key;
		logic [15:0] mv;
		logic [6:0]  cd;
		logic [63:0] word;
		int          old_depth;
		int          new_depth;
		out_item_t   r;
		slot = it.key[INDEX_BITS_DEF-1:0];
		chk  = check_tab.exists(slot) ? check_tab[slot] : 64'd0;
		dat  = data_tab.exists(slot) ? data_tab[slot] : 64'd0;
		old_key   = chk ^ dat;
		old_depth = dat[13:7];
		new_depth = it.depth;
		if (it.action == ACT_PROBE) begin
			r = '0;
			if ((chk ^ it.key) == dat) begin
				r.hit         = 1'b1;
				r.entry_age   = dat[6:0];
				r.entry_depth = dat[13:7];
				r.entry_bound = dat[15:14];
				r.entry_move  = dat[31:16];
				r.entry_eval  = dat[47:32];
				r.entry_value = mate_shift(dat[63:48], it.ply, 1'b0);
			end
			probe_results.push_back(r);
		end else if (dat[6:0] != model_age || old_key != it.key || it.bound == BOUND_EXACT ||
				old_depth < new_depth) begin
			// same key with no move given: the old move survives
			mv   = (old_key == it.key && it.move == MOVE_NONE) ? dat[31:16] : it.move;
			cd   = (new_depth < 0) ? 7'd0 : new_depth[6:0];
			word = {mate_shift(it.value, it.ply, 1'b1), it.eval, mv, it.bound, cd, model_age};
			check_tab[slot] = it.key ^ word;
			data_tab[slot]  = word;
		end
	endfunction

	function automatic in_item_t make_item(input logic action, input logic [63:0] key,
			input int ply, input int depth, input int bound, input int move,
			input int eval, input int value);
		in_item_t it;
		it.action = action;
		it.key    = key;
		it.ply    = ply[7:0];
		it.depth  = depth[7:0];
		it.bound  = bound[1:0];
		it.move   = move[15:0];
		it.eval   = eval[15:0];
		it.value  = value[15:0];
		return it;
	endfunction

	// Random transfer: mostly pool keys so stores and probes meet, some fresh
	// keys for misses, scores often sitting right on the mate threshold.
	function automatic in_item_t random_item();
		in_item_t it;
		int       v;
		it.action = 1'($urandom_range(1));
		it.key    = ($urandom_range(9) < 8) ? key_pool[$urandom_range(POOL_SIZE - 1)]
				: {$urandom, $urandom};
		it.ply    = 8'($urandom);
		it.depth  = ($urandom_range(2) == 0) ? 8'($urandom) : 8'($urandom_range(24));
		it.bound  = 2'($urandom);
		it.move   = ($urandom_range(3) == 0) ? MOVE_NONE : 16'($urandom);
		it.eval   = 16'($urandom);
		case ($urandom_range(7))
			0: v = model_thr;
			1: v = int'(model_thr) - 1;
			2: v = -int'(model_thr);
			3: v = 1 - int'(model_thr);
			4: v = 32767;
			5: v = -32768;
			default: v = $urandom;
		endcase
		it.value = v[15:0];
		return it;
	endfunction

	task automatic check_field(input string name, input logic [15:0] want,
			input logic [15:0] got);
		if (want !== got) begin
			errors++;
			$display("%0t: %s expected %h, got %h", $time, name, want, got);
		end
	endtask

	// ------------------------------------------------------------------------
	// Driver: input channel and result stall change on the falling edge.
	// A held transfer stays put until taken; calm stretches switch idling and stalling off.
	// ------------------------------------------------------------------------
	always @(negedge clk) begin
		if (calm_left != 0) begin
			calm_left <= calm_left - 1;
		end else if ($urandom_range(199) == 0) begin
			calm_left <= 40;
		end
		out_stall <= (calm_left == 0) && ($urandom_range(99) < recv_stall_pct);
		if (!in_valid || in_taken) begin
			if (pending_items.size() != 0 &&
					(calm_left != 0 || $urandom_range(99) >= send_idle_pct)) begin
				in_item  <= pending_items.pop_front();
				in_valid <= 1'b1;
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// ------------------------------------------------------------------------
	// Monitor: both transfers are sampled on the rising edge. The model is
	// updated in acceptance order, which is the order the block works in.
	// ------------------------------------------------------------------------
	always @(posedge clk) begin
		out_item_t want;
		cycles = cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("%0t: timeout, %0d results outstanding", $time, probe_results.size());
			$display("hash_table_probe_replace test failed");
			$finish;
		end else begin
			in_taken = arst_n && in_valid && !in_stall;
			if (in_taken) begin
				apply_table_op(in_item);
			end
			if (arst_n && out_valid && !out_stall) begin
				if (probe_results.size() == 0) begin
					errors++;
					$display("%0t: result expected none, got %h", $time, out_item);
				end else begin
					want = probe_results.pop_front();
					check_field("hit",         want.hit,         out_item.hit);
					check_field("entry_age",   want.entry_age,   out_item.entry_age);
					check_field("entry_depth", want.entry_depth, out_item.entry_depth);
					check_field("entry_bound", want.entry_bound, out_item.entry_bound);
					check_field("entry_move",  want.entry_move,  out_item.entry_move);
					check_field("entry_eval",  want.entry_eval,  out_item.entry_eval);
					check_field("entry_value", want.entry_value, out_item.entry_value);
				end
			end
		end
	end

	// Hold off until every queued transfer is taken and every probe answered,
	// then give trailing stores time to land in the table.
	task automatic drain();
		while (pending_items.size() != 0 || in_valid || probe_results.size() != 0) begin
			@(posedge clk);
		end
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// APB write: setup cycle, then access cycle; takes effect at the edge
	// where pready is seen with psel/penable/pwrite high.
	task automatic write_reg(input logic [2:0] addr, input logic [31:0] data);
		@(negedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= addr;
		pwdata  <= data;
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		if (addr == ADDR_AGE) begin
			model_age = data[6:0];
		end else if (addr == ADDR_THR) begin
			model_thr = data[14:0];
		end
		@(negedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
	endtask

	initial begin
		logic [63:0] r;
		logic [63:0] ka;
		logic [63:0] kb;
		logic [63:0] kc;
		int          ph;
		int          n;
		ka = 64'h0123_4567_89AB_CDEF;
		kb = 64'hFEDC_BA98_7654_CDEF;	// same slot as ka
		kc = 64'h8000_0000_0000_1234;
		// every third pool key collides with its neighbor's slot
		for (n = 0; n < POOL_SIZE; n++) begin
			r = {$urandom, $urandom};
			key_pool[n] = (n % 3 == 1) ? {r[63:16], key_pool[n - 1][15:0]} : r;
		end

		repeat (3) @(negedge clk);
		arst_n = 1'b1;

		// Directed part, reset register values. The block sits in its
		// clearing pass first; the driver just holds the first transfer.
		// cleared slot: key zero hits with all fields zero, any other key misses
		pending_items.push_back(make_item(ACT_PROBE, 64'd0, 0, 0, 0, 0, 0, 0));
		pending_items.push_back(make_item(ACT_PROBE, 64'hFFFF_0000_0000_0000,
				255, 127, 3, 65535, -1, -1));
		// extreme fields; mate score wraps past the top on store
		pending_items.push_back(make_item(ACT_STORE, ka, 255, 127, 3, 65535, 32767, 32767));
		pending_items.push_back(make_item(ACT_PROBE, ka, 0, 0, 0, 0, 0, 0));
		pending_items.push_back(make_item(ACT_PROBE, ka, 255, 0, 0, 0, 0, 0));
		// same key and age, not exact, not deeper: slot kept
		pending_items.push_back(make_item(ACT_STORE, ka, 9, -128, 0, 0, -32768, -32768));
		pending_items.push_back(make_item(ACT_PROBE, ka, 1, 0, 0, 0, 0, 0));
		// exact bound replaces; empty move keeps the old one
		pending_items.push_back(make_item(ACT_STORE, ka, 4, 5, 3, 0, 1, 100));
		pending_items.push_back(make_item(ACT_PROBE, ka, 4, 0, 0, 0, 0, 0));
		// other key in the same slot replaces, empty move stays empty
		pending_items.push_back(make_item(ACT_STORE, kb, 7, 0, 1, 0, -1, -32000));
		pending_items.push_back(make_item(ACT_PROBE, ka, 7, 0, 0, 0, 0, 0));
		pending_items.push_back(make_item(ACT_PROBE, kb, 7, 0, 0, 0, 0, 0));
		// negative depth packs as zero
		pending_items.push_back(make_item(ACT_STORE, kc, 255, -5, 2, 16'h1234, 0, -32768));
		pending_items.push_back(make_item(ACT_PROBE, kc, 3, 0, 0, 0, 0, 0));
		pending_items.push_back(make_item(ACT_STORE, kc, 0, 0, 1, 5, 2, 3));
		pending_items.push_back(make_item(ACT_STORE, kc, 0, 1, 0, 0, 2, 3));
		pending_items.push_back(make_item(ACT_PROBE, kc, 0, 0, 0, 0, 0, 0));
		pending_items.push_back(make_item(ACT_STORE, '1, 200, 127, 2, 16'h8000, -32768, 31999));
		pending_items.push_back(make_item(ACT_PROBE, '1, 200, 0, 0, 0, 0, 0));
		pending_items.push_back(make_item(ACT_STORE, '1, 200, 126, 1, 1, 5, 32000));
		pending_items.push_back(make_item(ACT_STORE, 64'd0, 100, 3, 0, 7, 8, 32000));
		pending_items.push_back(make_item(ACT_PROBE, 64'd0, 100, 0, 0, 0, 0, 0));
		pending_items.push_back(make_item(ACT_PROBE, '1, 55, 0, 0, 0, 0, 0));

		// Random phases, each with its own register setting and idle pattern.
		for (ph = 0; ph < 4; ph++) begin
			drain();
			case (ph)
				0: begin
					write_reg(ADDR_AGE, 32'd127);
					write_reg(ADDR_THR, 32'd0);
					send_idle_pct  = 0;
					recv_stall_pct = 0;
				end
				1: begin
					write_reg(ADDR_AGE, 32'd1);
					write_reg(ADDR_THR, 32'd32767);
					send_idle_pct  = 85;
					recv_stall_pct = 0;
				end
				2: begin
					write_reg(ADDR_AGE, 32'd0);
					write_reg(ADDR_THR, 32'd1);
					send_idle_pct  = 0;
					recv_stall_pct = 85;
				end
				default: begin
					write_reg(ADDR_AGE, 32'd63);
					write_reg(ADDR_THR, 32'd32000);
					send_idle_pct  = 27;
					recv_stall_pct = 27;
				end
			endcase
			for (n = 0; n < PHASE_ITEMS; n++) begin
				// halfway through, the sender holds back until the block is empty
				if (n == PHASE_ITEMS / 2) begin
					drain();
				end
				pending_items.push_back(random_item());
			end
		end

		drain();
		if (errors == 0) begin
			$display("hash_table_probe_replace test passed");
		end else begin
			$display("hash_table_probe_replace test failed");
		end
		$finish;
	end

endmodule
